// File: design/assert_macros.svh
// Assertion macros shared by the beat clock RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled during reset
`define CHK_PROP(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);

// Clocked implication, disabled during reset
`define CHK_IMP(lbl, ck, rn, ante, cons, msg) \
    `CHK_PROP(lbl, ck, rn, (ante) |-> (cons), msg)

`endif

// File: design/mbc_pkg.sv
// Package for the metronome beat clock: widths, codes, types.
// No dependencies; imported by mbc_divider and metronome_beat_clock_core.
package mbc_pkg;

    localparam int COUNT_BITS_DEF = 24;
    localparam int BPM_BITS_DEF   = 10;
    localparam int RATE_BITS      = 18;
    localparam int SCALE_BITS     = RATE_BITS + 6;
    localparam int SECS_PER_MIN   = 60;

    localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(48000);

    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_STOP  = 3'd2;
    localparam logic [2:0] ACT_TEMPO = 3'd3;
    localparam logic [2:0] ACT_KIND  = 3'd4;

    localparam logic [1:0] KIND_NORMAL = 2'd1;
    localparam logic [1:0] SOUND_NONE  = 2'd0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOD,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// File: design/mbc_divider.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on mbc_pkg (div_status_t); used by metronome_beat_clock_core.
module mbc_divider
    import mbc_pkg::*;
#(
    parameter int DW = SCALE_BITS,
    parameter int VW = COUNT_BITS_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output div_status_t   status,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] quo_reg, quo_next;
    logic [VW-1:0] rem_reg, rem_next;
    logic [VW-1:0] dvs_reg, dvs_next;

    logic [VW:0]   trial;
    logic [VW:0]   diff;
    logic          fits;

    assign trial = {rem_reg, quo_reg[DW-1]};
    assign diff  = trial - {1'b0, dvs_reg};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[DW-2:0], fits};
            rem_next = fits ? diff[VW-1:0] : trial[VW-1:0];
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;
    assign remainder   = rem_reg;

endmodule

// File: design/metronome_beat_clock_core.sv
// Metronome beat clock: one request in, one result out, each through a register.
// For a frame tick while running with a nonzero beat interval, the frame count modulo
// the beat interval comes out of the bit-serial divider one bit per cycle, the divider
// being DIV_W wide, the wider of COUNT_BITS and 24. A tick that lands on a beat and
// brings in a pending tempo, and a start or tempo request that makes a tempo active,
// run that divider again for 60*sample_rate/bpm. Stop, beat type, other ticks, other
// start or tempo requests and unused codes skip the divider.
// Depends on mbc_pkg, mbc_divider and assert_macros.svh.
`include "assert_macros.svh"

module metronome_beat_clock_core
    import mbc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF,
    parameter int BPM_BITS   = BPM_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [RATE_BITS-1:0] cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [2:0]           action,
    input  logic [BPM_BITS-1:0]  tempo_bpm,
    input  logic [1:0]           beat_kind,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 beat_fired,
    output logic [1:0]           sound_select,
    output logic [BPM_BITS-1:0]  reported_bpm,
    output logic                 running
);

    localparam int DIV_W = (COUNT_BITS > SCALE_BITS) ? COUNT_BITS : SCALE_BITS;

    state_t                 state_reg, state_next;
    logic [RATE_BITS-1:0]   sample_rate_reg, sample_rate_next;
    logic                   running_reg, running_next;
    logic [COUNT_BITS-1:0]  frame_reg, frame_next;
    logic [COUNT_BITS-1:0]  interval_reg, interval_next;
    logic [BPM_BITS-1:0]    active_reg, active_next;
    logic [BPM_BITS-1:0]    pending_reg, pending_next;
    logic [1:0]             kind_reg, kind_next;
    logic                   fired_reg, fired_next;
    logic [1:0]             sound_reg, sound_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   beat_fired_reg, beat_fired_next;
    logic [1:0]             sound_select_reg, sound_select_next;
    logic [BPM_BITS-1:0]    reported_reg, reported_next;
    logic                   running_out_reg, running_out_next;

    logic                   div_start;
    logic [DIV_W-1:0]       div_dividend;
    logic [COUNT_BITS-1:0]  div_divisor;
    div_status_t            div_status;
    logic [DIV_W-1:0]       div_quotient;
    logic [COUNT_BITS-1:0]  div_remainder;

    logic [SCALE_BITS-1:0]  scaled_rate;
    logic                   accept;
    logic                   tick_mod;
    logic                   tempo_div;
    logic                   beat_div;
    logic                   on_beat;
    logic                   out_free;
    logic                   iv_sat;

    assign scaled_rate = SCALE_BITS'(sample_rate_reg) * SCALE_BITS'(SECS_PER_MIN);
    assign accept      = in_valid && (state_reg == ST_IDLE);
    assign tick_mod    = (action == ACT_TICK) && running_reg && (interval_reg != '0);
    assign tempo_div   = ((action == ACT_START) || (action == ACT_TEMPO))
                         && ((active_reg == '0) || !running_reg) && (tempo_bpm != '0);
    assign beat_div    = (active_reg != pending_reg) && (pending_reg != '0);
    assign on_beat     = div_remainder == '0;
    assign out_free    = !out_valid_reg || !out_stall;
    assign iv_sat      = (div_quotient >> COUNT_BITS) != '0;

    mbc_divider #(
        .DW (DIV_W),
        .VW (COUNT_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .status    (div_status),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (tick_mod)
                        state_next = ST_MOD;
                    else if (tempo_div)
                        state_next = ST_DIV;
                    else
                        state_next = ST_DONE;
                end
            end
            ST_MOD:
            begin
                if (div_status.done)
                    state_next = (on_beat && beat_div) ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                if (div_status.done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        sample_rate_next  = cfg_we ? cfg_wdata : sample_rate_reg;
        running_next      = running_reg;
        frame_next        = frame_reg;
        interval_next     = interval_reg;
        active_next       = active_reg;
        pending_next      = pending_reg;
        kind_next         = kind_reg;
        fired_next        = fired_reg;
        sound_next        = sound_reg;
        out_valid_next    = out_valid_reg && out_stall;
        beat_fired_next   = beat_fired_reg;
        sound_select_next = sound_select_reg;
        reported_next     = reported_reg;
        running_out_next  = running_out_reg;
        div_start         = 1'b0;
        div_dividend      = DIV_W'(scaled_rate);
        div_divisor       = COUNT_BITS'(tempo_bpm);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    fired_next = 1'b0;
                    sound_next = SOUND_NONE;
                    unique case (action) inside
                        ACT_TICK:
                        begin
                            if (tick_mod)
                            begin
                                div_start    = 1'b1;
                                div_dividend = DIV_W'(frame_reg);
                                div_divisor  = interval_reg;
                            end
                            else if (running_reg)
                                frame_next = frame_reg + COUNT_BITS'(1);
                        end
                        ACT_START, ACT_TEMPO:
                        begin
                            pending_next = tempo_bpm;
                            if (tempo_div)
                            begin
                                active_next = tempo_bpm;
                                div_start   = 1'b1;
                            end
                            if (action == ACT_START)
                            begin
                                frame_next   = '0;
                                running_next = 1'b1;
                            end
                        end
                        ACT_STOP:
                        begin
                            frame_next   = '0;
                            running_next = 1'b0;
                            pending_next = active_reg;
                        end
                        ACT_KIND: kind_next = beat_kind;
                        default: ;
                    endcase
                end
            end
            ST_MOD:
            begin
                if (div_status.done)
                begin
                    if (on_beat)
                    begin
                        fired_next = 1'b1;
                        sound_next = kind_reg;
                        kind_next  = KIND_NORMAL;
                        frame_next = COUNT_BITS'(1);
                        if (beat_div)
                        begin
                            active_next = pending_reg;
                            div_start   = 1'b1;
                            div_divisor = COUNT_BITS'(pending_reg);
                        end
                    end
                    else
                        frame_next = frame_reg + COUNT_BITS'(1);
                end
            end
            ST_DIV:
            begin
                if (div_status.done)
                    interval_next = iv_sat ? '1 : div_quotient[COUNT_BITS-1:0];
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next    = 1'b1;
                    beat_fired_next   = fired_reg;
                    sound_select_next = sound_reg;
                    reported_next     = active_reg;
                    running_out_next  = running_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_rate_reg  <= RATE_RESET;
            running_reg      <= 1'b0;
            frame_reg        <= '0;
            interval_reg     <= '0;
            active_reg       <= '0;
            pending_reg      <= '0;
            kind_reg         <= KIND_NORMAL;
            fired_reg        <= 1'b0;
            sound_reg        <= SOUND_NONE;
            out_valid_reg    <= 1'b0;
            beat_fired_reg   <= 1'b0;
            sound_select_reg <= SOUND_NONE;
            reported_reg     <= '0;
            running_out_reg  <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            sample_rate_reg  <= sample_rate_next;
            running_reg      <= running_next;
            frame_reg        <= frame_next;
            interval_reg     <= interval_next;
            active_reg       <= active_next;
            pending_reg      <= pending_next;
            kind_reg         <= kind_next;
            fired_reg        <= fired_next;
            sound_reg        <= sound_next;
            out_valid_reg    <= out_valid_next;
            beat_fired_reg   <= beat_fired_next;
            sound_select_reg <= sound_select_next;
            reported_reg     <= reported_next;
            running_out_reg  <= running_out_next;
        end
    end

    assign in_stall     = state_reg != ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign beat_fired   = beat_fired_reg;
    assign sound_select = sound_select_reg;
    assign reported_bpm = reported_reg;
    assign running      = running_out_reg;

    `CHK_IMP(a_out_done, clk, rst_n, $rose(out_valid), $past(state_reg == ST_DONE), "stray result")
    `CHK_IMP(a_div_start_idle, clk, rst_n, div_start, !div_status.busy, "divider busy")
    `CHK_IMP(a_beat_running, clk, rst_n, out_valid && beat_fired, running, "beat while stopped")

endmodule
